@@ rtl/fpcp_pkg.sv @@
package fpcp_pkg;

    // Default for the longest count that a command line may carry.
    localparam int MAX_DIGITS_DEF = 4;

    // Length of the fixed "@019UNU " prefix.
    localparam int PREFIX_LEN = 8;

    localparam logic [7:0] CHAR_AT    = 8'h40;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_U     = 8'h55;
    localparam logic [7:0] CHAR_N     = 8'h4E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // ASCII '0' at six bits, shown in columns that hold no captured digit.
    localparam logic [5:0] SHOW_ZERO = 6'h30;

    typedef enum logic [1:0] {
        ST_READING  = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_REJECTED = 2'd2
    } match_status_t;

    typedef enum logic {
        OP_FEED    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

    // One result item. The last field sits in the lowest bits.
    typedef struct packed {
        logic [5:0]    digit_ones;
        logic [5:0]    digit_tens;
        logic [5:0]    digit_hundreds;
        logic [5:0]    digit_thousands;
        logic [2:0]    digit_count;
        match_status_t status;
    } result_t;

    // Expected character at each prefix position.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CHAR_AT;
            3'd1:    c = CHAR_0;
            3'd2:    c = CHAR_1;
            3'd3:    c = CHAR_9;
            3'd4:    c = CHAR_U;
            3'd5:    c = CHAR_N;
            3'd6:    c = CHAR_U;
            3'd7:    c = CHAR_SPACE;
            default: c = CHAR_AT;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/fpcp_matcher.sv @@
module fpcp_matcher #(
    parameter int MAX_DIGITS = fpcp_pkg::MAX_DIGITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              restart,
    input  logic [7:0]        char_in,
    output fpcp_pkg::result_t result_next
);
    import fpcp_pkg::*;

    localparam int POS_CR_I = PREFIX_LEN + MAX_DIGITS;
    localparam int POS_LF_I = POS_CR_I + 1;
    localparam int POS_W    = $clog2(POS_LF_I + 1);
    localparam int HELD_W   = $clog2(MAX_DIGITS + 1);

    localparam logic [POS_W-1:0]  POS_PREFIX_END = POS_W'(PREFIX_LEN);
    localparam logic [POS_W-1:0]  POS_CR         = POS_W'(POS_CR_I);
    localparam logic [POS_W-1:0]  POS_LF         = POS_W'(POS_LF_I);
    localparam logic [HELD_W-1:0] HELD_MAX       = HELD_W'(MAX_DIGITS);

    match_status_t     status_reg, status_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [HELD_W-1:0] held_reg, held_next;
    // Last four captured digits as low nibbles, entry 0 is the ones column.
    logic [3:0][3:0]   digit_sh_reg, digit_sh_next;

    logic is_digit;

    assign is_digit = (char_in inside {[CHAR_0:CHAR_9]});

    always_comb
    begin
        status_next   = status_reg;
        pos_next      = pos_reg;
        held_next     = held_reg;
        digit_sh_next = digit_sh_reg;
        if (restart)
        begin
            status_next = ST_READING;
            pos_next    = '0;
            held_next   = '0;
        end
        else if (status_reg == ST_READING)
        begin
            if (pos_reg < POS_PREFIX_END)
            begin
                if (char_in == prefix_char(pos_reg[2:0]))
                    pos_next = pos_reg + POS_W'(1);
                else
                    status_next = ST_REJECTED;
            end
            else if (pos_reg < POS_CR)
            begin
                if (is_digit)
                begin
                    if (held_reg < HELD_MAX)
                    begin
                        held_next     = held_reg + HELD_W'(1);
                        digit_sh_next = {digit_sh_reg[2:0], char_in[3:0]};
                    end
                    pos_next = pos_reg + POS_W'(1);
                end
                else if ((pos_reg != POS_PREFIX_END) && (char_in == CHAR_CR))
                    pos_next = POS_LF;
                else
                    status_next = ST_REJECTED;
            end
            else if (pos_reg == POS_CR)
            begin
                if (char_in == CHAR_CR)
                    pos_next = POS_LF;
                else
                    status_next = ST_REJECTED;
            end
            else if (pos_reg == POS_LF)
                status_next = (char_in == CHAR_LF) ? ST_ACCEPTED : ST_REJECTED;
            else
                status_next = ST_REJECTED;
        end
    end

    // Right-aligned view of the count after this item.
    always_comb
    begin
        result_next.status          = status_next;
        result_next.digit_count     = 3'(held_next);
        result_next.digit_ones      = (int'(held_next) > 0) ? {2'b11, digit_sh_next[0]}
                                                             : SHOW_ZERO;
        result_next.digit_tens      = (int'(held_next) > 1) ? {2'b11, digit_sh_next[1]}
                                                             : SHOW_ZERO;
        result_next.digit_hundreds  = (int'(held_next) > 2) ? {2'b11, digit_sh_next[2]}
                                                             : SHOW_ZERO;
        result_next.digit_thousands = (int'(held_next) > 3) ? {2'b11, digit_sh_next[3]}
                                                             : SHOW_ZERO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_READING;
            pos_reg    <= '0;
            held_reg   <= '0;
        end
        else if (step)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            held_reg   <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            digit_sh_reg <= digit_sh_next;
    end

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_MAX)
        else $error("digit count exceeds the maximum");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && restart |=> (status_reg == ST_READING) && (held_reg == '0) && (pos_reg == '0))
        else $error("restart did not clear the matcher");

    a_final_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg != ST_READING) && !(step && restart) |=> $stable(status_reg))
        else $error("final status changed without a restart");

    a_held_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == ST_READING) && (pos_reg >= POS_PREFIX_END) && (pos_reg < POS_CR)
        |-> (POS_W'(held_reg) == pos_reg - POS_PREFIX_END))
        else $error("digit count out of step with match position");
`endif

endmodule

@@ rtl/fpcp_out_reg.sv @@
module fpcp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  fpcp_pkg::result_t result_in,
    output logic              can_load,
    output logic              valid,
    input  logic              ready,
    output fpcp_pkg::result_t result
);
    import fpcp_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    // A new result may enter when the register is empty or is being drained.
    assign can_load = !valid_reg || ready;
    assign valid    = valid_reg;
    assign result   = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (can_load)
            valid_reg <= load;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

endmodule

@@ rtl/fixed_prefix_count_command_parser_core.sv @@
// A result request appears on the master side in the cycle after its input request is taken.
// Throughput: one input request per cycle; the single result register is refilled in the same
// cycle that it drains, so only a stalled master side holds back the slave side.
// Reset: rst_n is asynchronous and active low; it sets the matcher to reading at the at sign
// with no digits captured and empties the result register.
module fixed_prefix_count_command_parser_core #(
    parameter int MAX_DIGITS = fpcp_pkg::MAX_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tuser,   // [0] opcode (0 feed character, 1 restart)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [1:0] status, [4:2] digit_count,
                                        // [10:5] digit_thousands, [16:11] digit_hundreds,
                                        // [22:17] digit_tens, [28:23] digit_ones, [31:29] zero
);
    import fpcp_pkg::*;

    logic    in_take;
    logic    can_load;
    result_t result_next;
    result_t result_out;

    // An input request is taken whenever the result register can accept its result.
    assign s_axis_tready = can_load;
    assign in_take       = s_axis_tvalid && can_load;

    // The matcher holds the line state and computes, in one pass, the state and the
    // right-aligned digit view that follow the incoming request.
    fpcp_matcher #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_matcher (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_take),
        .restart     (s_axis_tuser == OP_RESTART),
        .char_in     (s_axis_tdata),
        .result_next (result_next)
    );

    // The result register parts the two sides of the block.
    fpcp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_take),
        .result_in (result_next),
        .can_load  (can_load),
        .valid     (m_axis_tvalid),
        .ready     (m_axis_tready),
        .result    (result_out)
    );

    assign m_axis_tdata = {3'b000, result_out};

endmodule

@@ verif/fixed_prefix_count_command_parser_core_tb.sv @@
module fixed_prefix_count_command_parser_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fpcp_pkg::*;

    // The block is built with its default digit limit, so the predictor uses the same one.
    localparam int MAX_DIGITS = MAX_DIGITS_DEF;

    // Position of the matcher that waits for CR once every allowed digit is in, and the
    // position that waits for LF right after CR.
    localparam int CR_POS = PREFIX_LEN + MAX_DIGITS;
    localparam int LF_POS = CR_POS + 1;

    // The "@019UNU " prefix as a byte string, first character in the lowest byte.
    localparam logic [63:0] PREFIX_BYTES = {CHAR_SPACE, CHAR_U, CHAR_N, CHAR_U,
                                            CHAR_9, CHAR_1, CHAR_0, CHAR_AT};

    // Requests to send in total, directed part included.
    localparam int REQUEST_TARGET = 1300;

    // Cycles allowed after the last reply is in, before the verdict.
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    // Replies predicted for accepted requests, oldest first.
    result_t     replies_due[$];

    int          requests_sent = 0;
    int          replies_seen = 0;
    int          mismatch_count = 0;

    // Idle control shared by the sender, the receiver and the tests. A nonzero hold request
    // makes the receiver keep tready low for a stall of that length.
    bit          tx_pauses = 1'b1;
    bit          rx_pauses = 1'b1;
    int          hold_request = 0;

    // Predictor state: where the matcher stands in the line and what it has captured.
    match_status_t line_status;
    int            line_pos;
    int            captured_count;
    logic [7:0]    captured_digit[MAX_DIGITS];

    fixed_prefix_count_command_parser_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ends a run that hangs. The slowest correct run stays far below this: every request
    // can wait out the longest sender gap plus the longest receiver stall and still fit
    // several times over.
    initial
    begin
        #5_000_000;
        $display("fixed_prefix_count_command_parser_core_tb: errors");
        $finish;
    end

    // Gap length for either side: mostly none, often a few cycles, rarely a long stretch.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void clear_line_state();
        line_status    = ST_READING;
        line_pos       = 0;
        captured_count = 0;
    endfunction

    // Advances the predicted matcher by one character while it is still reading.
    function automatic void match_char(input logic [7:0] ch);
        logic is_digit;
        is_digit = (ch >= CHAR_0) && (ch <= CHAR_9);
        if (line_pos < PREFIX_LEN)
        begin
            if (ch == PREFIX_BYTES[8*line_pos +: 8])
                line_pos++;
            else
                line_status = ST_REJECTED;
        end
        else if (line_pos < CR_POS)
        begin
            // CR may end the count after any digit but never stand in place of the first.
            if (is_digit)
            begin
                if (captured_count < MAX_DIGITS)
                begin
                    captured_digit[captured_count] = ch;
                    captured_count++;
                end
                line_pos++;
            end
            else if (line_pos != PREFIX_LEN && ch == CHAR_CR)
                line_pos = LF_POS;
            else
                line_status = ST_REJECTED;
        end
        else if (line_pos == CR_POS)
        begin
            // All allowed digits are in, so a further digit rejects the line.
            if (ch == CHAR_CR)
                line_pos = LF_POS;
            else
                line_status = ST_REJECTED;
        end
        else if (line_pos == LF_POS)
            line_status = (ch == CHAR_LF) ? ST_ACCEPTED : ST_REJECTED;
        else
            line_status = ST_REJECTED;
    endfunction

    // Works out the reply to one request and updates the predicted matcher.
    function automatic result_t predict_reply(input opcode_t op, input logic [7:0] ch);
        result_t    reply;
        logic [5:0] column[4];
        int         from_right;
        if (op == OP_RESTART)
            clear_line_state();
        else if (line_status == ST_READING)
            match_char(ch);
        // Digits are shown right-aligned in four columns, padded with ASCII zeros.
        for (int k = 0; k < 4; k++)
        begin
            from_right = 3 - k;
            column[k]  = SHOW_ZERO;
            if (from_right < captured_count)
                column[k] = captured_digit[captured_count - 1 - from_right][5:0];
        end
        reply.status          = line_status;
        reply.digit_count     = 3'(captured_count);
        reply.digit_thousands = column[0];
        reply.digit_hundreds  = column[1];
        reply.digit_tens      = column[2];
        reply.digit_ones      = column[3];
        return reply;
    endfunction

    // Offers one request and returns once it is accepted. Handshake signals are looked at
    // on the falling edge, where everything driven at the rising edge has settled, and
    // the request counts as taken at the rising edge that follows.
    task automatic send_request(input opcode_t op, input logic [7:0] ch);
        int gap;
        gap = tx_pauses ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= op;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        replies_due.push_back(predict_reply(op, ch));
        requests_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_request(OP_FEED, text[i]);
    endtask

    task automatic send_prefix();
        for (int k = 0; k < PREFIX_LEN; k++)
            send_request(OP_FEED, PREFIX_BYTES[8*k +: 8]);
    endtask

    // Receiver: random stalls on tready, plus the long hold that a test may ask for.
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall        = hold_request;
                hold_request = 0;
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                stall = rx_pauses ? pick_gap() : 0;
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Reply checker: every reply taken is compared with the oldest prediction.
    always @(negedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            replies_seen++;
            if (replies_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("reply %0d arrived with no request pending: tdata %h",
                             replies_seen, m_axis_tdata);
            end
            else
            begin
                want = replies_due.pop_front();
                if (got.status !== want.status || got.digit_count !== want.digit_count ||
                    got.digit_thousands !== want.digit_thousands ||
                    got.digit_hundreds !== want.digit_hundreds ||
                    got.digit_tens !== want.digit_tens || got.digit_ones !== want.digit_ones)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"reply %0d: expected status %0d count %0d digits %h %h %h %h,",
                                  " got status %0d count %0d digits %h %h %h %h"},
                                 replies_seen, want.status, want.digit_count,
                                 want.digit_thousands, want.digit_hundreds, want.digit_tens,
                                 want.digit_ones, got.status, got.digit_count,
                                 got.digit_thousands, got.digit_hundreds, got.digit_tens,
                                 got.digit_ones);
                end
            end
        end
    end

    // Restart straight out of reset, with every bit of the ignored character set.
    task automatic test_restart_from_reset();
        send_request(OP_RESTART, 8'hFF);
    endtask

    // The longest count with the extreme digits; CR has to follow the last allowed digit.
    task automatic test_full_length_accept();
        send_text("@019UNU 9090\r\n");
    endtask

    // Once the line is accepted, fed characters change nothing until a restart.
    task automatic test_finished_line();
        send_request(OP_FEED, 8'hFF);
        send_request(OP_FEED, CHAR_AT);
        send_request(OP_RESTART, 8'h00);
    endtask

    // CR where the first digit belongs rejects the line like any other non-digit.
    task automatic test_cr_before_digit();
        send_prefix();
        send_request(OP_FEED, CHAR_CR);
        send_request(OP_RESTART, 8'h5A);
    endtask

    // A wrong first character rejects at once, and the rejection sticks.
    task automatic test_prefix_mismatch();
        send_request(OP_FEED, 8'h00);
        send_request(OP_FEED, CHAR_0);
        send_request(OP_RESTART, 8'hA5);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering requests
    // back to back, so the result register fills and the input side has to stall.
    task automatic test_backpressure();
        tx_pauses    = 1'b0;
        hold_request = 150;
        send_text("@019UNU 42\r\n");
        for (int k = 0; k < 6; k++)
            send_request(OP_FEED, 8'($urandom_range(0, 255)));
        send_request(OP_RESTART, 8'($urandom_range(0, 255)));
        tx_pauses = 1'b1;
    endtask

    // Random lines: half of them well-formed with random digits, the rest broken in various ways
    // or plain noise. Every line is followed by a restart so the next one starts clean.
    task automatic test_random_lines();
        logic [7:0] line_q[$];
        int         flaw;
        int         n_digits;
        int         cut;
        int         tail;
        while (requests_sent < REQUEST_TARGET)
        begin
            // Some lines run with no idling on one side or the other.
            tx_pauses = ($urandom_range(0, 3) != 0);
            rx_pauses = ($urandom_range(0, 3) != 0);
            line_q.delete();
            flaw     = $urandom_range(0, 11);
            n_digits = $urandom_range(1, MAX_DIGITS);
            if (flaw == 7)
                n_digits = MAX_DIGITS + $urandom_range(1, 2);
            else if (flaw == 8)
                n_digits = 0;
            for (int k = 0; k < PREFIX_LEN; k++)
                line_q.push_back(PREFIX_BYTES[8*k +: 8]);
            for (int k = 0; k < n_digits; k++)
                line_q.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
            line_q.push_back(CHAR_CR);
            line_q.push_back(CHAR_LF);
            case (flaw)
                5:
                    line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
                6:
                begin
                    // Cut the line short; the restart then lands in the middle of it.
                    cut = $urandom_range(0, line_q.size() - 1);
                    while (line_q.size() > cut)
                        void'(line_q.pop_back());
                end
                9:
                    line_q[line_q.size() - 1] = 8'($urandom_range(0, 255));
                default:
                    ;
            endcase
            if (flaw == 11)
            begin
                for (int k = $urandom_range(1, 8); k > 0; k--)
                    send_request(opcode_t'(1'($urandom_range(0, 1))), 8'($urandom_range(0, 255)));
            end
            else
            begin
                foreach (line_q[i])
                    send_request(OP_FEED, line_q[i]);
            end
            tail = $urandom_range(0, 2);
            for (int k = 0; k < tail; k++)
                send_request(OP_FEED, 8'($urandom_range(0, 255)));
            send_request(OP_RESTART, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        clear_line_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_restart_from_reset();
        test_full_length_accept();
        test_finished_line();
        test_cr_before_digit();
        test_prefix_mismatch();
        test_backpressure();
        test_random_lines();

        s_axis_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && replies_due.size() == 0)
            $display("fixed_prefix_count_command_parser_core_tb: clean");
        else
            $display("fixed_prefix_count_command_parser_core_tb: errors");
        $finish;
    end

endmodule
